@@ sv/rbc_pkg.sv @@
// rbc_pkg: shared types and constants of the ring burst counter
// used by rbc_cfg, rbc_step and ring_burst_counter_top; no dependencies
package rbc_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned RunW     = 8;
  localparam int unsigned TickW    = 16;
  localparam int unsigned CountW   = 8;

  // register indexes on the config port
  localparam logic [CfgIdxW-1:0] CFG_RISE_RUN  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_FALL_RUN  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_START_TMO = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_GAP_LIMIT = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_RINGS_REQ = 3'd4;

  localparam logic [RunW-1:0]   RISE_RUN_RST  = 8'd10;
  localparam logic [RunW-1:0]   FALL_RUN_RST  = 8'd10;
  localparam logic [TickW-1:0]  START_TMO_RST = 16'd800;
  localparam logic [TickW-1:0]  GAP_LIMIT_RST = 16'd20;
  localparam logic [CountW-1:0] RINGS_REQ_RST = 8'd3;

  localparam logic [RunW-1:0]  RUN_MAX  = '1;
  localparam logic [TickW-1:0] TICK_MAX = '1;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_RISE = 4'b0010,
    PH_FALL = 4'b0100,
    PH_GAP  = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [RunW-1:0]   rise_run_length;
    logic [RunW-1:0]   fall_run_length;
    logic [TickW-1:0]  ring_start_timeout;
    logic [TickW-1:0]  pulse_gap_limit;
    logic [CountW-1:0] rings_required;
  } cfg_t;

  typedef struct packed {
    logic start_req;
    logic ring_level;
    logic tick;
    logic abort_level;
  } item_t;

  typedef struct packed {
    logic              busy_res;
    logic              done_res;
    logic              status;
    logic [CountW-1:0] rings_seen;
    logic [CountW-1:0] pulses_in_ring;
  } res_t;

endpackage

@@ sv/rbc_cfg.sv @@
// rbc_cfg: configuration register file of the ring burst counter
// depends on rbc_pkg
module rbc_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [rbc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [rbc_pkg::CfgDataW-1:0] cfg_wdata,
  output rbc_pkg::cfg_t                cfg
);

  rbc_pkg::cfg_t cfg_r;
  rbc_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        rbc_pkg::CFG_RISE_RUN:  cfg_nxt.rise_run_length    = cfg_wdata[rbc_pkg::RunW-1:0];
        rbc_pkg::CFG_FALL_RUN:  cfg_nxt.fall_run_length    = cfg_wdata[rbc_pkg::RunW-1:0];
        rbc_pkg::CFG_START_TMO: cfg_nxt.ring_start_timeout = cfg_wdata[rbc_pkg::TickW-1:0];
        rbc_pkg::CFG_GAP_LIMIT: cfg_nxt.pulse_gap_limit    = cfg_wdata[rbc_pkg::TickW-1:0];
        rbc_pkg::CFG_RINGS_REQ: cfg_nxt.rings_required     = cfg_wdata[rbc_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rise_run_length    <= rbc_pkg::RISE_RUN_RST;
      cfg_r.fall_run_length    <= rbc_pkg::FALL_RUN_RST;
      cfg_r.ring_start_timeout <= rbc_pkg::START_TMO_RST;
      cfg_r.pulse_gap_limit    <= rbc_pkg::GAP_LIMIT_RST;
      cfg_r.rings_required     <= rbc_pkg::RINGS_REQ_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ sv/rbc_step.sv @@
// rbc_step: phase machine and counters, one sample per enable
// depends on rbc_pkg
module rbc_step (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  rbc_pkg::item_t item,
  input  rbc_pkg::cfg_t  cfg,
  output rbc_pkg::res_t  res
);

  rbc_pkg::phase_t               phase_r, phase_nxt;
  logic [rbc_pkg::RunW-1:0]      run_r, run_nxt;
  logic [rbc_pkg::TickW-1:0]     tick_r, tick_nxt;
  logic [rbc_pkg::CountW-1:0]    rings_r, rings_nxt;
  logic [rbc_pkg::CountW-1:0]    pulses_r, pulses_nxt;

  logic                          run_match;
  logic [rbc_pkg::RunW-1:0]      run_need;
  logic [rbc_pkg::RunW-1:0]      run_inc;
  logic                          run_hit;
  logic [rbc_pkg::TickW-1:0]     tick_inc;
  logic [rbc_pkg::CountW-1:0]    rings_inc;
  logic                          done;
  logic                          cancel;

  // shared run counter: low samples in fall search, high samples otherwise
  always_comb begin
    run_match = (phase_r == rbc_pkg::PH_FALL) ? !item.ring_level : item.ring_level;
    run_need  = (phase_r == rbc_pkg::PH_FALL) ? cfg.fall_run_length : cfg.rise_run_length;
    if (!run_match) begin
      run_inc = '0;
    end else if (run_r == rbc_pkg::RUN_MAX) begin
      run_inc = run_r;
    end else begin
      run_inc = run_r + 1'b1;
    end
    run_hit   = (run_inc >= run_need);
    tick_inc  = (item.tick && (tick_r != rbc_pkg::TICK_MAX)) ? tick_r + 1'b1 : tick_r;
    rings_inc = rings_r + 1'b1;
  end

  always_comb begin
    phase_nxt  = phase_r;
    run_nxt    = run_r;
    tick_nxt   = tick_r;
    rings_nxt  = rings_r;
    pulses_nxt = pulses_r;
    done       = 1'b0;
    cancel     = 1'b0;
    if (item.start_req) begin
      phase_nxt  = rbc_pkg::PH_RISE;
      run_nxt    = '0;
      tick_nxt   = '0;
      rings_nxt  = '0;
      pulses_nxt = '0;
    end else begin
      case (phase_r)
        rbc_pkg::PH_RISE: begin
          tick_nxt = tick_inc;
          if ((tick_inc >= cfg.ring_start_timeout) || item.abort_level) begin
            done   = 1'b1;
            cancel = 1'b1;
          end else begin
            run_nxt = run_inc;
            if (run_hit) begin
              phase_nxt = rbc_pkg::PH_FALL;
              run_nxt   = '0;
            end
          end
        end
        rbc_pkg::PH_FALL: begin
          run_nxt = run_inc;
          if (run_hit) begin
            pulses_nxt = pulses_r + 1'b1;
            run_nxt    = '0;
            tick_nxt   = '0;
            phase_nxt  = rbc_pkg::PH_GAP;
          end
        end
        rbc_pkg::PH_GAP: begin
          tick_nxt = tick_inc;
          if (tick_inc >= cfg.pulse_gap_limit) begin
            rings_nxt = rings_inc;
            if (item.abort_level) begin
              done   = 1'b1;
              cancel = 1'b1;
            end else if (rings_inc >= cfg.rings_required) begin
              done = 1'b1;
            end else begin
              phase_nxt  = rbc_pkg::PH_RISE;
              run_nxt    = '0;
              tick_nxt   = '0;
              pulses_nxt = '0;
            end
          end else if (item.abort_level) begin
            done   = 1'b1;
            cancel = 1'b1;
          end else begin
            run_nxt = run_inc;
            if (run_hit) begin
              phase_nxt = rbc_pkg::PH_FALL;
              run_nxt   = '0;
            end
          end
        end
        default: ;
      endcase
    end
    if (done) begin
      phase_nxt = rbc_pkg::PH_IDLE;
      run_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= rbc_pkg::PH_IDLE;
      run_r    <= '0;
      tick_r   <= '0;
      rings_r  <= '0;
      pulses_r <= '0;
    end else if (en) begin
      phase_r  <= phase_nxt;
      run_r    <= run_nxt;
      tick_r   <= tick_nxt;
      rings_r  <= rings_nxt;
      pulses_r <= pulses_nxt;
    end
  end

  always_comb begin
    res.busy_res       = (phase_nxt != rbc_pkg::PH_IDLE);
    res.done_res       = done;
    res.status         = cancel;
    res.rings_seen     = rings_nxt;
    res.pulses_in_ring = pulses_nxt;
  end

endmodule

@@ sv/ring_burst_counter_top.sv @@
// ring_burst_counter_top: input register, step logic and result register
// depends on rbc_pkg, rbc_cfg and rbc_step
//
//   port group   direction  handshake           payload
//   in_*         in         in_valid/in_stall   start_req ring_level tick abort_level
//   out_*        out        out_valid/out_stall busy_res done_res status rings_seen
//                                               pulses_in_ring
//   cfg_*        in         cfg_we              cfg_index cfg_wdata
//
// one word per clock while out_stall does not hold the flow; a word passes the input register, then the result register
// the phase machine and counters update as a word moves into the result register
// reset clears the valid flags, the phase machine and counters, and loads the config registers with their defaults
// out_stall holds a valid result register and backs up into in_stall in the same cycle
module ring_burst_counter_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_start_req,
  input  logic                         in_ring_level,
  input  logic                         in_tick,
  input  logic                         in_abort_level,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_busy_res,
  output logic                         out_done_res,
  output logic                         out_status,
  output logic [rbc_pkg::CountW-1:0]   out_rings_seen,
  output logic [rbc_pkg::CountW-1:0]   out_pulses_in_ring,
  input  logic                         cfg_we,
  input  logic [rbc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [rbc_pkg::CfgDataW-1:0] cfg_wdata
);

  rbc_pkg::cfg_t  cfg;
  rbc_pkg::item_t in_item_r;
  rbc_pkg::res_t  step_res;
  rbc_pkg::res_t  out_res_r;
  logic           in_valid_r;
  logic           out_valid_r;
  logic           move;
  logic           step_en;
  logic           in_take;

  assign move     = !out_valid_r || !out_stall;
  assign step_en  = in_valid_r && move;
  assign in_stall = in_valid_r && !move;
  assign in_take  = in_valid && !in_stall;

  rbc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  rbc_step u_step (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (step_en),
    .item  (in_item_r),
    .cfg   (cfg),
    .res   (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      if (move) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r.start_req   <= in_start_req;
      in_item_r.ring_level  <= in_ring_level;
      in_item_r.tick        <= in_tick;
      in_item_r.abort_level <= in_abort_level;
    end
    if (step_en) begin
      out_res_r <= step_res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_busy_res       = out_res_r.busy_res;
  assign out_done_res       = out_res_r.done_res;
  assign out_status         = out_res_r.status;
  assign out_rings_seen     = out_res_r.rings_seen;
  assign out_pulses_in_ring = out_res_r.pulses_in_ring;

endmodule

@@ dv/tb_top.sv @@
// tb_top: self-checking testbench for ring_burst_counter_top, scoreboard class and drivers
// depends on rbc_pkg and ring_burst_counter_top
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_WORDS = 40;

  localparam int RUN_W   = rbc_pkg::RunW;
  localparam int TICK_W  = rbc_pkg::TickW;
  localparam int COUNT_W = rbc_pkg::CountW;
  localparam int DATA_W  = rbc_pkg::CfgDataW;
  localparam int ITEM_W  = $bits(rbc_pkg::item_t);

  // start, level, tick, abort
  localparam logic [3:0] DIRECTED_WORDS [24] = '{
    4'b0111, 4'b1111, 4'b0010, 4'b0111, 4'b1000, 4'b0001,
    4'b1000, 4'b0100, 4'b0101, 4'b0000, 4'b0100, 4'b0000,
    4'b0011, 4'b1000, 4'b0100, 4'b0000, 4'b0010, 4'b1000,
    4'b0100, 4'b0000, 4'b0001, 4'b1000, 4'b1110, 4'b0110
  };

  class ring_wait_scoreboard;
    rbc_pkg::cfg_t              regs;
    rbc_pkg::phase_t            phase;
    logic [rbc_pkg::RunW-1:0]   run_len;
    logic [rbc_pkg::TickW-1:0]  ticks;
    logic [rbc_pkg::CountW-1:0] rings;
    logic [rbc_pkg::CountW-1:0] pulses;
    rbc_pkg::res_t              expected_words[$];
    int                         errors;

    function new();
      regs.rise_run_length    = rbc_pkg::RISE_RUN_RST;
      regs.fall_run_length    = rbc_pkg::FALL_RUN_RST;
      regs.ring_start_timeout = rbc_pkg::START_TMO_RST;
      regs.pulse_gap_limit    = rbc_pkg::GAP_LIMIT_RST;
      regs.rings_required     = rbc_pkg::RINGS_REQ_RST;
      phase  = rbc_pkg::PH_IDLE;
      run_len = '0;
      ticks  = '0;
      rings  = '0;
      pulses = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [rbc_pkg::CfgIdxW-1:0] idx,
                            logic [rbc_pkg::CfgDataW-1:0] val);
      case (idx)
        rbc_pkg::CFG_RISE_RUN:  regs.rise_run_length    = val[rbc_pkg::RunW-1:0];
        rbc_pkg::CFG_FALL_RUN:  regs.fall_run_length    = val[rbc_pkg::RunW-1:0];
        rbc_pkg::CFG_START_TMO: regs.ring_start_timeout = val[rbc_pkg::TickW-1:0];
        rbc_pkg::CFG_GAP_LIMIT: regs.pulse_gap_limit    = val[rbc_pkg::TickW-1:0];
        rbc_pkg::CFG_RINGS_REQ: regs.rings_required     = val[rbc_pkg::CountW-1:0];
        default: ;
      endcase
    endfunction

    function bit count_run(bit match, logic [rbc_pkg::RunW-1:0] need);
      if (match) begin
        if (run_len != rbc_pkg::RUN_MAX) run_len++;
      end else begin
        run_len = '0;
      end
      return run_len >= need;
    endfunction

    function void advance_wait(rbc_pkg::item_t w);
      bit            done;
      bit            cancel;
      rbc_pkg::res_t r;
      done   = 1'b0;
      cancel = 1'b0;
      if (w.start_req) begin
        phase   = rbc_pkg::PH_RISE;
        run_len = '0;
        ticks   = '0;
        rings   = '0;
        pulses  = '0;
      end else begin
        case (phase)
          rbc_pkg::PH_RISE: begin
            if (w.tick && ticks != rbc_pkg::TICK_MAX) ticks++;
            if (ticks >= regs.ring_start_timeout || w.abort_level) begin
              done   = 1'b1;
              cancel = 1'b1;
            end else if (count_run(w.ring_level, regs.rise_run_length)) begin
              phase   = rbc_pkg::PH_FALL;
              run_len = '0;
            end
          end
          rbc_pkg::PH_FALL: begin
            if (count_run(!w.ring_level, regs.fall_run_length)) begin
              pulses++;
              run_len = '0;
              ticks   = '0;
              phase   = rbc_pkg::PH_GAP;
            end
          end
          rbc_pkg::PH_GAP: begin
            if (w.tick && ticks != rbc_pkg::TICK_MAX) ticks++;
            if (ticks >= regs.pulse_gap_limit) begin
              rings++;
              if (w.abort_level) begin
                done   = 1'b1;
                cancel = 1'b1;
              end else if (rings >= regs.rings_required) begin
                done = 1'b1;
              end else begin
                phase   = rbc_pkg::PH_RISE;
                run_len = '0;
                ticks   = '0;
                pulses  = '0;
              end
            end else if (w.abort_level) begin
              done   = 1'b1;
              cancel = 1'b1;
            end else if (count_run(w.ring_level, regs.rise_run_length)) begin
              phase   = rbc_pkg::PH_FALL;
              run_len = '0;
            end
          end
          default: ;
        endcase
      end
      if (done) begin
        phase   = rbc_pkg::PH_IDLE;
        run_len = '0;
      end
      r.busy_res       = (phase != rbc_pkg::PH_IDLE);
      r.done_res       = done;
      r.status         = cancel;
      r.rings_seen     = rings;
      r.pulses_in_ring = pulses;
      expected_words.push_back(r);
    endfunction

    function void compare_field(string field, int want, int got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_report(rbc_pkg::res_t got);
      rbc_pkg::res_t want;
      if (expected_words.size() == 0) begin
        $display("%0t: result word with nothing expected, expected none actual %h",
                 $time, got);
        errors++;
        return;
      end
      want = expected_words.pop_front();
      compare_field("busy_res", int'(want.busy_res), int'(got.busy_res));
      compare_field("done_res", int'(want.done_res), int'(got.done_res));
      compare_field("status", int'(want.status), int'(got.status));
      compare_field("rings_seen", int'(want.rings_seen), int'(got.rings_seen));
      compare_field("pulses_in_ring", int'(want.pulses_in_ring),
                    int'(got.pulses_in_ring));
    endfunction
  endclass

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_stall;
  logic                         in_start_req;
  logic                         in_ring_level;
  logic                         in_tick;
  logic                         in_abort_level;
  logic                         out_valid;
  logic                         out_stall;
  logic                         out_busy_res;
  logic                         out_done_res;
  logic                         out_status;
  logic [rbc_pkg::CountW-1:0]   out_rings_seen;
  logic [rbc_pkg::CountW-1:0]   out_pulses_in_ring;
  logic                         cfg_we;
  logic [rbc_pkg::CfgIdxW-1:0]  cfg_index;
  logic [rbc_pkg::CfgDataW-1:0] cfg_wdata;

  ring_wait_scoreboard sb = new();
  bit tx_quiet;
  bit rx_quiet;
  bit hold_req;
  int words_sent;
  int quiet_cycles;

  ring_burst_counter_top DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_start_req       (in_start_req),
    .in_ring_level      (in_ring_level),
    .in_tick            (in_tick),
    .in_abort_level     (in_abort_level),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_busy_res       (out_busy_res),
    .out_done_res       (out_done_res),
    .out_status         (out_status),
    .out_rings_seen     (out_rings_seen),
    .out_pulses_in_ring (out_pulses_in_ring),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic send_word(rbc_pkg::item_t w);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    {in_start_req, in_ring_level, in_tick, in_abort_level} <= w;
    do @(posedge clk); while (in_stall);
    sb.advance_wait(w);
    words_sent++;
  endtask

  // a run of one level, with rare glitches and aborts unless clean
  task automatic send_level(bit lvl, int count, int tick_odds, bit clean);
    rbc_pkg::item_t w;
    repeat (count) begin
      w = '0;
      w.ring_level = lvl;
      if (!clean && $urandom_range(0, 39) == 0) w.ring_level = !lvl;
      w.tick = ($urandom_range(1, tick_odds) == 1);
      w.abort_level = !clean && ($urandom_range(0, 299) == 0);
      send_word(w);
    end
  endtask

  task automatic send_noise(int count);
    rbc_pkg::item_t w;
    repeat (count) begin
      w = rbc_pkg::item_t'(ITEM_W'($urandom));
      w.start_req   = ($urandom_range(0, 7) == 0);
      w.abort_level = ($urandom_range(0, 5) == 0);
      send_word(w);
    end
  endtask

  task automatic play_ring_wait();
    rbc_pkg::item_t w;
    int             n_rings;
    w = rbc_pkg::item_t'(ITEM_W'($urandom));
    w.start_req = 1'b1;
    send_word(w);
    if ($urandom_range(0, 9) == 0 && sb.regs.ring_start_timeout <= 64)
      send_level(1'b0, sb.regs.ring_start_timeout + 2, 1, 1'b0);
    n_rings = sb.regs.rings_required + ($urandom_range(0, 3) == 0);
    repeat (n_rings) begin
      repeat ($urandom_range(1, 3)) begin
        send_level(1'b1, sb.regs.rise_run_length + $urandom_range(0, 2), 8, 1'b0);
        send_level(1'b0, sb.regs.fall_run_length + $urandom_range(0, 2), 8, 1'b0);
      end
      send_level(1'b0, sb.regs.pulse_gap_limit + $urandom_range(0, 2), 1, 1'b0);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.expected_words.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [rbc_pkg::CfgIdxW-1:0] idx,
                           logic [rbc_pkg::CfgDataW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic set_config(logic [rbc_pkg::RunW-1:0] rise, logic [rbc_pkg::RunW-1:0] fall,
                            logic [rbc_pkg::TickW-1:0] tmo, logic [rbc_pkg::TickW-1:0] gap,
                            logic [rbc_pkg::CountW-1:0] rings);
    write_reg(rbc_pkg::CFG_RISE_RUN, DATA_W'(rise));
    write_reg(rbc_pkg::CFG_FALL_RUN, DATA_W'(fall));
    write_reg(rbc_pkg::CFG_START_TMO, tmo);
    write_reg(rbc_pkg::CFG_GAP_LIMIT, gap);
    write_reg(rbc_pkg::CFG_RINGS_REQ, DATA_W'(rings));
    cfg_we <= 1'b0;
  endtask

  // result side: random stalls, one long hold on request
  initial begin
    int stall_len;
    out_stall <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      if (hold_req) begin
        stall_len = HOLD_CYCLES;
        hold_req  = 1'b0;
      end else begin
        stall_len = rx_quiet ? 0 : $urandom_range(0, 14);
      end
      if (stall_len > 0) begin
        out_stall <= 1'b1;
        repeat (stall_len) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_report({out_busy_res, out_done_res, out_status, out_rings_seen,
                       out_pulses_in_ring});
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
      $display("ring_burst_counter_top test failed");
      $finish;
    end
  end

  initial begin
    int first_word;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_start_req   <= 1'b0;
    in_ring_level  <= 1'b0;
    in_tick        <= 1'b0;
    in_abort_level <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= '0;
    cfg_wdata      <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // shortest runs and gap limit, start timeout 2, one ring
    set_config(8'd1, 8'd1, 16'd2, 16'd1, 8'd1);
    foreach (DIRECTED_WORDS[i]) send_word(rbc_pkg::item_t'(DIRECTED_WORDS[i]));

    for (int ph = 0; ph < 8; ph++) begin
      drain();
      if (ph == 2)
        set_config(rbc_pkg::RISE_RUN_RST, rbc_pkg::FALL_RUN_RST, rbc_pkg::START_TMO_RST,
                   rbc_pkg::GAP_LIMIT_RST, rbc_pkg::RINGS_REQ_RST);
      else if (ph == 5)
        set_config(rbc_pkg::RUN_MAX, rbc_pkg::RUN_MAX, rbc_pkg::TICK_MAX,
                   rbc_pkg::TICK_MAX, '1);
      else
        set_config(RUN_W'($urandom_range(1, 4)), RUN_W'($urandom_range(1, 4)),
                   TICK_W'($urandom_range(4, 40)), TICK_W'($urandom_range(1, 6)),
                   COUNT_W'($urandom_range(1, 3)));
      tx_quiet = ($urandom_range(0, 2) == 0);
      rx_quiet = ($urandom_range(0, 2) == 0);
      if (ph == 3) begin
        tx_quiet = 1'b1;
        hold_req = 1'b1;
      end
      if (ph == 5) begin
        // longest rise run reaches fall search, abort ignored there
        send_word(rbc_pkg::item_t'(4'b1000));
        send_level(1'b1, 270, 64, 1'b1);
        send_level(1'b0, 20, 64, 1'b1);
        send_word(rbc_pkg::item_t'(4'b0001));
        send_word(rbc_pkg::item_t'(4'b1000));
        send_word(rbc_pkg::item_t'(4'b0101));
      end else begin
        first_word = words_sent;
        while (words_sent - first_word < PHASE_WORDS) begin
          if ($urandom_range(0, 4) == 0)
            send_noise($urandom_range(5, 20));
          else
            play_ring_wait();
        end
      end
    end

    drain();
    if (sb.errors == 0)
      $display("ring_burst_counter_top test passed");
    else
      $display("ring_burst_counter_top test failed");
    $finish;
  end

endmodule

@@ filelist.f @@
sv/rbc_pkg.sv
sv/rbc_cfg.sv
sv/rbc_step.sv
sv/ring_burst_counter_top.sv
dv/tb_top.sv
